// ===== hdl/modular_binomial_table_core_macros.svh =====
// Assertion macros shared by the checker
`ifndef MODULAR_BINOMIAL_TABLE_CORE_MACROS_SVH
`define MODULAR_BINOMIAL_TABLE_CORE_MACROS_SVH
// assert that a implies b in the next cycle
`define MBT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// assert that a implies b in the same cycle
`define MBT_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

// ===== hdl/mbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_pkg
// Types and constants for the modular binomial table core.
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int unsigned ModW = 30;
    localparam int unsigned SizeW = 17;
    localparam int unsigned MaxN = 65536;
    localparam logic [ModW-1:0] ModReset = 30'd998244353;

    typedef enum logic [2:0] {
        CMD_BUILD = 3'd0,
        CMD_FACT  = 3'd1,
        CMD_IFACT = 3'd2,
        CMD_BINOM = 3'd3,
        CMD_POWER = 3'd4
    } cmd_e;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_MODULUS    = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [19:0] index_n;
        logic [19:0] index_k;
        logic [30:0] base;
        logic [30:0] exponent;
    } in_word_t;

    typedef struct packed {
        logic [29:0] value;
        logic        error;
    } out_word_t;

    // datapath operations driven by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_ONE,   // acc <= 1 mod m
        OP_MUL_ACC_I,  // acc <= acc * i
        OP_MUL_ACC_RD, // acc <= acc * rdata
        OP_MUL_P_P,    // p <= p * p
        OP_MUL_ACC_P,  // acc <= acc * p
        OP_LOAD_P_ACC, // p <= acc, acc <= 1 mod m
        OP_LOAD_P_BASE,// p <= base mod m on the multiplier
        OP_LOAD_ACC_RD // acc <= rdata
    } op_e;

    typedef enum logic [4:0] {
        ST_IDLE, ST_F_INIT, ST_F_MUL, ST_F_WAIT, ST_INV_INIT, ST_PW_CHK,
        ST_PW_MUL, ST_PW_SQ, ST_I_WR, ST_I_MUL, ST_I_WAIT, ST_MUL_ZERO_WR,
        ST_Q_RD, ST_Q_RDW, ST_Q_B1, ST_Q_B1W, ST_Q_B2, ST_Q_B2W, ST_Q_B3W,
        ST_P_RED, ST_P_REDW, ST_DONE
    } state_e;

    typedef struct packed {
        op_e         op;
        logic        mod_sel_cur;  // use current modulus, else latched
        logic        fact_we;
        logic        ifact_we;
        logic        rd_ifact;
        logic [16:0] addr;
        logic        mul_start;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_busy;
    } dp_stat_t;

endpackage

// ===== hdl/mbt_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_mulmod
// Sequential modular multiplier: radix-2 shift-add, one bit per cycle.
// ----------------------------------------------------------------------------
module mbt_mulmod
    import mbt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [ModW:0]   a,
    input  logic [ModW-1:0] b,
    input  logic [ModW-1:0] m,
    output logic            busy,
    output logic [ModW-1:0] prod
);

    logic [ModW:0]   a_reg, a_next;
    logic [ModW-1:0] m_reg;
    logic [ModW-1:0] b_hold;
    logic [ModW-1:0] r_reg, r_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [ModW:0]   dbl;
    logic [ModW:0]   dbl_red;
    logic [ModW:0]   add;

    always_comb
    begin
        // r = 2r, plus b when the top bit of a is set, kept below m
        dbl = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        add = dbl_red + {1'b0, b_hold};
        r_next = r_reg;
        a_next = a_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            r_next = '0;
            a_next = a;
            cnt_next = 5'(ModW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg[ModW])
                r_next = (add >= {1'b0, m_reg}) ? ModW'(add - {1'b0, m_reg}) : ModW'(add);
            else
                r_next = ModW'(dbl_red);
            a_next = {a_reg[ModW-1:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        r_reg <= r_next;
        if (start)
        begin
            // caller keeps b already reduced below m
            b_hold <= (b >= m) ? b - m : b;
            m_reg <= m;
        end
    end

    assign busy = busy_reg;
    assign prod = r_reg;

endmodule

// ===== hdl/mbt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_datapath
// Table memories, accumulator, power register and the shared multiplier.
// ----------------------------------------------------------------------------
module mbt_datapath
    import mbt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  dp_cmd_t         cmd,
    input  logic [ModW-1:0] mod_cur,
    input  logic [ModW-1:0] mod_lat,
    input  logic [ModW-1:0] mul_i,
    input  logic [30:0]     base,
    output dp_stat_t        stat,
    output logic [ModW-1:0] acc
);

    logic [ModW-1:0] fact_mem [MaxN+1];
    logic [ModW-1:0] ifact_mem [MaxN+1];
    logic [ModW-1:0] rdata_reg;
    logic [ModW-1:0] acc_reg, acc_next;
    logic [ModW-1:0] p_reg, p_next;
    logic [ModW-1:0] m;
    logic [ModW:0]   mul_a;
    logic [ModW-1:0] mul_b, prod;
    logic            busy;
    logic            busy_d_reg;
    op_e             op_last_reg;

    assign m = cmd.mod_sel_cur ? mod_cur : mod_lat;

    always_ff @(posedge clk)
    begin
        if (cmd.fact_we)
            fact_mem[cmd.addr] <= acc_reg;
        if (cmd.ifact_we)
            ifact_mem[cmd.addr] <= acc_reg;
        rdata_reg <= cmd.rd_ifact ? ifact_mem[cmd.addr] : fact_mem[cmd.addr];
    end

    always_comb
    begin
        mul_a = {1'b0, acc_reg};
        mul_b = p_reg;
        unique case (cmd.op)
            OP_MUL_ACC_I:
            begin
                // index drives the multiplier bits, so it needs no reduction
                mul_a = {1'b0, mul_i};
                mul_b = acc_reg;
            end
            OP_MUL_ACC_RD: mul_b = rdata_reg;
            OP_MUL_P_P:    mul_a = {1'b0, p_reg};
            OP_LOAD_P_BASE:
            begin
                // base times one reduces the base below m
                mul_a = base;
                mul_b = ModW'(1);
            end
            default: ;
        endcase
    end

    mbt_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .m     (m),
        .busy  (busy),
        .prod  (prod)
    );

    always_comb
    begin
        acc_next = acc_reg;
        p_next = p_reg;
        unique case (cmd.op)
            OP_LOAD_ONE:    acc_next = (m == 30'd1) ? '0 : 30'd1;
            OP_LOAD_P_ACC:
            begin
                p_next = acc_reg;
                acc_next = (m == 30'd1) ? '0 : 30'd1;
            end
            OP_LOAD_ACC_RD: acc_next = rdata_reg;
            default: ;
        endcase
        // capture product when the multiplier finishes
        if (busy_d_reg && !busy)
        begin
            if (op_last_reg == OP_MUL_P_P || op_last_reg == OP_LOAD_P_BASE)
                p_next = prod;
            else
                acc_next = prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_d_reg <= 1'b0;
            op_last_reg <= OP_NONE;
        end
        else
        begin
            busy_d_reg <= busy;
            if (cmd.mul_start)
                op_last_reg <= cmd.op;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        p_reg <= p_next;
    end

    assign stat.mul_busy = busy | busy_d_reg;
    assign acc = acc_reg;

endmodule

// ===== hdl/mbt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_ctrl
// Command sequencer for build, table queries, binomial and power.
// ----------------------------------------------------------------------------
module mbt_ctrl
    import mbt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  in_word_t        operand,
    input  logic [SizeW-1:0] table_size,
    input  logic [ModW-1:0] modulus,
    input  dp_stat_t        stat,
    input  logic [ModW-1:0] acc,
    output dp_cmd_t         cmd,
    output logic [ModW-1:0] mod_cur,
    output logic [ModW-1:0] mod_lat,
    output logic [ModW-1:0] mul_i,
    output logic [30:0]     base,
    output logic            busy,
    output logic            done,
    output out_word_t       result
);

    state_e state_reg, state_next;
    in_word_t op_reg;
    logic [SizeW-1:0] i_reg, i_next;
    logic [SizeW-1:0] top_reg, top_next;
    logic [SizeW-1:0] built_reg, built_next;
    logic built_ok_reg, built_ok_next;
    logic [ModW-1:0] mlat_reg, mlat_next;
    logic [30:0] e_reg, e_next;
    logic err_reg, err_next;
    logic zero_val_reg, zero_val_next;
    logic [ModW-1:0] meff;
    logic [19:0] nk;

    assign meff = (modulus < 30'd2) ? 30'd2 : modulus;
    assign mod_cur = meff;
    assign mod_lat = mlat_reg;
    assign mul_i = ModW'(i_reg);
    assign base = op_reg.base;
    assign nk = op_reg.index_n - op_reg.index_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            built_reg <= '0;
            built_ok_reg <= 1'b0;
            mlat_reg <= 30'd2;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
            built_ok_reg <= built_ok_next;
            mlat_reg <= mlat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == ST_IDLE)
            op_reg <= operand;
        i_reg <= i_next;
        top_reg <= top_next;
        e_reg <= e_next;
        err_reg <= err_next;
        zero_val_reg <= zero_val_next;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        top_next = top_reg;
        built_next = built_reg;
        built_ok_next = built_ok_reg;
        mlat_next = mlat_reg;
        e_next = e_reg;
        err_next = err_reg;
        zero_val_next = zero_val_reg;
        cmd = '0;
        cmd.op = OP_NONE;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    err_next = 1'b0;
                    zero_val_next = 1'b0;
                    unique case (operand.command)
                        CMD_BUILD:
                        begin
                            top_next = (table_size > SizeW'(MaxN)) ? SizeW'(MaxN)
                                                                   : table_size;
                            mlat_next = meff;
                            state_next = ST_F_INIT;
                        end
                        CMD_FACT, CMD_IFACT:
                        begin
                            if (!built_ok_reg || operand.index_n > 20'(built_reg))
                            begin
                                err_next = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_Q_RD;
                        end
                        CMD_BINOM:
                        begin
                            if (!built_ok_reg || operand.index_k > operand.index_n
                                || operand.index_n > 20'(built_reg))
                            begin
                                err_next = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_Q_B1;
                        end
                        CMD_POWER:
                            state_next = ST_P_RED;
                        default:
                        begin
                            err_next = 1'b1;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_F_INIT:
            begin
                cmd.op = OP_LOAD_ONE;
                i_next = SizeW'(1);
                state_next = ST_F_WAIT;
                zero_val_next = 1'b1;
            end
            ST_F_WAIT:
            begin
                // write fact[i-1] from acc, then multiply by i
                cmd.mod_sel_cur = 1'b0;
                cmd.addr = i_reg - SizeW'(1);
                cmd.fact_we = 1'b1;
                if (i_reg > top_reg)
                    state_next = ST_INV_INIT;
                else
                begin
                    cmd.op = OP_MUL_ACC_I;
                    cmd.mul_start = 1'b1;
                    state_next = ST_F_MUL;
                end
            end
            ST_F_MUL:
            begin
                cmd.op = OP_MUL_ACC_I;
                if (!stat.mul_busy)
                begin
                    i_next = i_reg + SizeW'(1);
                    state_next = ST_F_WAIT;
                end
            end
            ST_INV_INIT:
            begin
                // p <= fact[top]; acc <= 1; exponent m-2
                cmd.op = OP_LOAD_P_ACC;
                e_next = {1'b0, mlat_reg - 30'd2};
                state_next = ST_PW_CHK;
                i_next = top_reg;
            end
            ST_PW_CHK:
            begin
                if (e_reg == '0)
                begin
                    if (op_reg.command == CMD_POWER)
                        state_next = ST_DONE;
                    else
                        state_next = ST_I_WR;
                end
                else if (e_reg[0])
                begin
                    cmd.op = OP_MUL_ACC_P;
                    cmd.mul_start = 1'b1;
                    state_next = ST_PW_MUL;
                end
                else
                begin
                    cmd.op = OP_MUL_P_P;
                    cmd.mul_start = 1'b1;
                    state_next = ST_PW_SQ;
                end
                cmd.mod_sel_cur = (op_reg.command == CMD_POWER);
            end
            ST_PW_MUL:
            begin
                cmd.mod_sel_cur = (op_reg.command == CMD_POWER);
                if (!stat.mul_busy)
                begin
                    cmd.op = OP_MUL_P_P;
                    cmd.mul_start = 1'b1;
                    state_next = ST_PW_SQ;
                end
            end
            ST_PW_SQ:
            begin
                cmd.mod_sel_cur = (op_reg.command == CMD_POWER);
                if (!stat.mul_busy)
                begin
                    e_next = e_reg >> 1;
                    state_next = ST_PW_CHK;
                end
            end
            ST_I_WR:
            begin
                cmd.addr = i_reg;
                cmd.ifact_we = 1'b1;
                if (i_reg <= SizeW'(1))
                    state_next = ST_I_WAIT;
                else
                begin
                    cmd.op = OP_MUL_ACC_I;
                    cmd.mul_start = 1'b1;
                    state_next = ST_I_MUL;
                end
            end
            ST_I_MUL:
            begin
                if (!stat.mul_busy)
                begin
                    i_next = i_reg - SizeW'(1);
                    state_next = ST_I_WR;
                end
            end
            ST_I_WAIT:
            begin
                // inverse factorial of zero is one
                cmd.op = OP_LOAD_ONE;
                state_next = ST_MUL_ZERO_WR;
            end
            ST_MUL_ZERO_WR:
            begin
                cmd.addr = '0;
                cmd.ifact_we = 1'b1;
                built_next = top_reg;
                built_ok_next = 1'b1;
                state_next = ST_DONE;
            end
            ST_Q_RD:
            begin
                cmd.addr = SizeW'(op_reg.index_n);
                cmd.rd_ifact = (op_reg.command == CMD_IFACT);
                state_next = ST_Q_RDW;
            end
            ST_Q_RDW:
            begin
                cmd.op = OP_LOAD_ACC_RD;
                state_next = ST_DONE;
            end
            ST_Q_B1:
            begin
                cmd.addr = SizeW'(op_reg.index_n);
                state_next = ST_Q_B1W;
            end
            ST_Q_B1W:
            begin
                cmd.op = OP_LOAD_ACC_RD;
                cmd.addr = SizeW'(op_reg.index_k);
                cmd.rd_ifact = 1'b1;
                state_next = ST_Q_B2;
            end
            ST_Q_B2:
            begin
                cmd.op = OP_MUL_ACC_RD;
                cmd.mul_start = 1'b1;
                cmd.addr = SizeW'(nk);
                cmd.rd_ifact = 1'b1;
                state_next = ST_Q_B2W;
            end
            ST_Q_B2W:
            begin
                cmd.addr = SizeW'(nk);
                cmd.rd_ifact = 1'b1;
                if (!stat.mul_busy)
                begin
                    cmd.op = OP_MUL_ACC_RD;
                    cmd.mul_start = 1'b1;
                    state_next = ST_Q_B3W;
                end
            end
            ST_Q_B3W:
            begin
                cmd.addr = SizeW'(nk);
                cmd.rd_ifact = 1'b1;
                if (!stat.mul_busy)
                    state_next = ST_DONE;
            end
            ST_P_RED:
            begin
                // reduce the base below the current modulus on the multiplier
                cmd.mod_sel_cur = 1'b1;
                cmd.op = OP_LOAD_P_BASE;
                cmd.mul_start = 1'b1;
                e_next = op_reg.exponent;
                state_next = ST_P_REDW;
            end
            ST_P_REDW:
            begin
                cmd.mod_sel_cur = 1'b1;
                if (!stat.mul_busy)
                begin
                    cmd.op = OP_LOAD_ONE;
                    state_next = ST_PW_CHK;
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign result.value = (err_reg || zero_val_reg) ? '0 : acc;
    assign result.error = err_reg;

endmodule

// ===== hdl/modular_binomial_table_core.sv =====
`timescale 1ns / 1ps
// Table query reads one entry; binomial multiplies fact[n] by ifact[k] and ifact[n-k]; power
// reduces the base, then squares per zero and multiplies and squares per one exponent bit.
// Rejected commands go straight to done. Products use the shared bit-serial modular multiplier.
// Build: both tables are filled by running products, plus one exponentiation to modulus-2.
// One command at a time, next start accepted in the cycle after done; results cannot be stalled.
// Reset: tables marked unbuilt, modulus 998244353, table_size 0.
// ----------------------------------------------------------------------------
// modular_binomial_table_core
// Factorial and inverse factorial tables mod a prime with table, binomial and power queries.
// ----------------------------------------------------------------------------
module modular_binomial_table_core
    import mbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_word_t    operand,
    output logic        busy,
    output logic        done,
    output out_word_t   result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [29:0] cfg_data
);

    logic [SizeW-1:0] table_size_reg;
    logic [ModW-1:0]  modulus_reg;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [ModW-1:0]  mod_cur, mod_lat, mul_i, acc;
    logic [30:0]      base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
            modulus_reg <= ModReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TABLE_SIZE)
                table_size_reg <= cfg_data[SizeW-1:0];
            else
                modulus_reg <= cfg_data;
        end
    end

    mbt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operand    (operand),
        .table_size (table_size_reg),
        .modulus    (modulus_reg),
        .stat       (stat),
        .acc        (acc),
        .cmd        (cmd),
        .mod_cur    (mod_cur),
        .mod_lat    (mod_lat),
        .mul_i      (mul_i),
        .base       (base),
        .busy       (busy),
        .done       (done),
        .result     (result)
    );

    mbt_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .mod_cur (mod_cur),
        .mod_lat (mod_lat),
        .mul_i   (mul_i),
        .base    (base),
        .stat    (stat),
        .acc     (acc)
    );

endmodule

// ===== hdl/modular_binomial_table_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_binomial_table_core_checker
// Port-level checks of the command handshake and result words.
// ----------------------------------------------------------------------------
`include "modular_binomial_table_core_macros.svh"
module modular_binomial_table_core_checker
    import mbt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_word_t result
);

    `MBT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `MBT_ASSERT_NOW(a_done_busy, clk, rst_n, done, busy)
    `MBT_ASSERT_NOW(a_err_zero, clk, rst_n, done && result.error, result.value == '0)
    `MBT_ASSERT_NEXT(a_done_once, clk, rst_n, done, !done)

endmodule

bind modular_binomial_table_core modular_binomial_table_core_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
